[hw/rtl/aes128_pkg.sv]
`timescale 1ns / 1ps
package aes128_pkg;

    localparam int BlockBits = 128;
    localparam int KeyBits   = 128;
    localparam int RegBits   = 64;

    typedef logic [BlockBits-1:0] t_block;
    typedef logic [KeyBits-1:0]   t_key;

    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_idx;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [0:255];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[a];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte i of a block sits at bits [127-8i -: 8]
    function automatic logic [7:0] get_byte(input t_block b, input int i);
        return b[BlockBits-1-8*i -: 8];
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BlockBits-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c+r)%4)));
            end
        end
        return t;
    endfunction

    function automatic t_block mix_cols(input t_block s);
        t_block     t;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            t[BlockBits-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            t[BlockBits-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            t[BlockBits-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            t[BlockBits-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic t_key next_key(input t_key k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

[hw/rtl/aes128_block_encrypt.sv]
`timescale 1ns / 1ps
// Channel     | Dir | Payload
// s_axis      | in  | tdata[63:0] plaintext_high, tdata[127:64] plaintext_low
// m_axis      | out | tdata[63:0] ciphertext_high, tdata[127:64] ciphertext_low
// cfg         | in  | index 0 key_high, index 1 key_low
// One block a cycle while the output is not stalled; one key-add stage and ten round stages,
// each stage holding one round and its own key expansion step.
// The key travels with the block, so a key write applies to blocks taken after it.
// Reset is synchronous, active low; it clears valid bits and the key registers.
// A stall on the output freezes the whole pipeline; nothing is dropped or repeated.
module aes128_block_encrypt
    import aes128_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // [63:0] plaintext_high, [127:64] plaintext_low
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [127:0]  m_axis_tdata,  // [63:0] ciphertext_high, [127:64] ciphertext_low
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);

    localparam int NumRounds = 10;
    // round constant of round g sits at bits [8g +: 8]
    localparam logic [8*NumRounds-1:0] Rcon =
        {8'h36, 8'h1b, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01};

    logic [RegBits-1:0] r_key_hi, r_key_lo;
    logic               w_en;
    logic               r_v0;
    t_block             r_s0;
    t_key               r_k0;
    logic               w_v [0:NumRounds];
    t_block             w_s [0:NumRounds];
    t_key               w_k [0:NumRounds];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_KEY_HIGH: r_key_hi <= i_cfg_data;
                REG_KEY_LOW:  r_key_lo <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // advance only when the last stage is empty or being drained
    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0 <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ {r_key_hi, r_key_lo};
            r_k0 <= {r_key_hi, r_key_lo};
        end
    end

    assign w_v[0] = r_v0;
    assign w_s[0] = r_s0;
    assign w_k[0] = r_k0;

    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        aes128_round #(
            .RCON  (Rcon[8*g +: 8]),
            .FINAL (g == NumRounds - 1)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_v[g]),
            .i_state (w_s[g]),
            .i_key   (w_k[g]),
            .o_valid (w_v[g+1]),
            .o_state (w_s[g+1]),
            .o_key   (w_k[g+1])
        );
    end

    assign m_axis_tvalid = w_v[NumRounds];
    assign m_axis_tdata  = {w_s[NumRounds][63:0], w_s[NumRounds][127:64]};

endmodule

[hw/rtl/aes128_round.sv]
`timescale 1ns / 1ps
// One pipeline stage: one cipher round plus the matching key expansion step.
module aes128_round
    import aes128_pkg::*;
#(
    parameter logic [7:0] RCON  = 8'h01,
    parameter bit         FINAL = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_block i_state,
    input  t_key   i_key,
    output logic   o_valid,
    output t_block o_state,
    output t_key   o_key
);

    t_block r_state, n_state, w_sub;
    t_key   r_key, n_key;
    logic   r_valid;

    always_comb begin
        n_key = next_key(i_key, RCON);
        w_sub = sub_shift(i_state);
        if (FINAL) begin
            n_state = w_sub ^ n_key;
        end else begin
            n_state = mix_cols(w_sub) ^ n_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;

endmodule
